// ----- hdl/assert_macros.svh -----
// assertion macros for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hdl/pfds_pkg.sv -----
// package: constants, types and decode functions for the statistics unit
package pfds_pkg;
    localparam logic [31:0] POS_INF = 32'h7F80_0000;
    localparam logic [31:0] NEG_INF = 32'hFF80_0000;
    localparam logic [31:0] QNAN    = 32'h7FC0_0000;
    localparam int          NCOMP   = 4;
    localparam int          OUT_BITS = 28;

    typedef enum logic [1:0] {
        FMT_UF111110 = 2'd0,
        FMT_HALF2    = 2'd1,
        FMT_UNORM4   = 2'd2,
        FMT_F32      = 2'd3
    } t_fmt;

    typedef struct packed {
        logic [NCOMP-1:0] vld;
        logic [NCOMP-1:0][31:0] val;
        logic last;
    } t_comps;

    // exact float32 of a nonzero 10-bit mantissa scaled by 2^(-14-mbits)
    function automatic logic [31:0] denorm_bits(input logic [9:0] mant,
                                                input logic [3:0] mbits);
        logic [3:0] p;
        logic [7:0] e;
        logic [32:0] sh;
        p = 4'd0;
        for (int i = 1; i < 10; i++) begin
            if (mant[i]) p = 4'(i);
        end
        e = 8'(8'd127 + {4'd0, p} - 8'd14 - {4'd0, mbits});
        sh = {23'd0, mant} << (5'd23 - {1'b0, p});
        denorm_bits = {1'b0, e, sh[22:0]};
    endfunction

    function automatic logic [31:0] ufloat_bits(input logic [10:0] bits,
                                                input logic six);
        logic [5:0] mant;
        logic [4:0] ex;
        if (six) begin
            mant = bits[5:0];
            ex = bits[10:6];
        end else begin
            mant = {1'b0, bits[4:0]};
            ex = bits[9:5];
        end
        if (ex == 5'd0)
            ufloat_bits = (mant != 6'd0) ?
                denorm_bits({4'd0, mant}, six ? 4'd6 : 4'd5) : 32'd0;
        else if (ex == 5'd31)
            ufloat_bits = (mant != 6'd0) ? QNAN : POS_INF;
        else if (six)
            ufloat_bits = {1'b0, 8'({3'd0, ex} + 8'd112), mant, 17'd0};
        else
            ufloat_bits = {1'b0, 8'({3'd0, ex} + 8'd112), mant[4:0], 18'd0};
    endfunction

    function automatic logic [31:0] half_bits(input logic [15:0] h);
        logic [4:0] ex;
        ex = h[14:10];
        if (ex == 5'd0)
            half_bits = (h[9:0] != 10'd0) ?
                ({h[15], 31'd0} | denorm_bits(h[9:0], 4'd10)) : {h[15], 31'd0};
        else if (ex == 5'd31)
            half_bits = {h[15], 8'hFF, h[9:0], 13'd0};
        else
            half_bits = {h[15], 8'({3'd0, ex} + 8'd112), h[9:0], 13'd0};
    endfunction

    // exact float32 of b/255, correctly rounded
    function automatic logic [31:0] unorm_calc(input logic [7:0] b);
        logic [7:0] k;
        logic [48:0] num;
        logic [48:0] q;
        logic [48:0] r;
        if (b == 8'd0) return 32'd0;
        k = 8'd23;
        num = 49'd0;
        q = 49'd0;
        for (int i = 0; i < 18; i++) begin
            num = {41'd0, b} << k;
            q = num / 49'd255;
            if (q >= 49'h80_0000 || k >= 8'd40) break;
            k = k + 8'd1;
        end
        r = num - q * 49'd255;
        if (2 * r > 49'd255) q = q + 49'd1;
        if (q >= 49'h100_0000) begin
            q = q >> 1;
            k = k - 8'd1;
        end
        unorm_calc = {1'b0, 8'(8'd150 - k), q[22:0]};
    endfunction

    typedef logic [255:0][31:0] t_utab;
    function automatic t_utab unorm_table();
        t_utab t;
        for (int i = 0; i < 256; i++) t[i] = unorm_calc(8'(i));
        return t;
    endfunction
    localparam t_utab UNORM_TAB = unorm_table();

    // total order key, -0 folded to +0
    function automatic logic [31:0] order_key(input logic [31:0] v);
        logic [31:0] a;
        a = (v[30:0] == 31'd0) ? 32'd0 : v;
        order_key = a[31] ? ~a : (a | 32'h8000_0000);
    endfunction
endpackage

// ----- hdl/pfds_if.sv -----
// valid/ready channel interface with generic payload
interface pfds_if #(parameter int W = 33) (input logic i_clk);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ----- hdl/pfds_decode.sv -----
// splits a registered word into components and decodes them to float32
module pfds_decode import pfds_pkg::*; (
    input  logic [1:0]  i_fmt,
    input  logic [31:0] i_word,
    input  logic        i_last,
    output t_comps      o_comps
);
    always_comb begin
        o_comps.last = i_last;
        o_comps.vld = '0;
        o_comps.val = '0;
        case (t_fmt'(i_fmt))
            FMT_UF111110: begin
                o_comps.vld = 4'b0111;
                o_comps.val[0] = ufloat_bits(i_word[10:0], 1'b1);
                o_comps.val[1] = ufloat_bits(i_word[21:11], 1'b1);
                o_comps.val[2] = ufloat_bits({1'b0, i_word[31:22]}, 1'b0);
            end
            FMT_HALF2: begin
                o_comps.vld = 4'b0011;
                o_comps.val[0] = half_bits(i_word[15:0]);
                o_comps.val[1] = half_bits(i_word[31:16]);
            end
            FMT_UNORM4: begin
                o_comps.vld = 4'b1111;
                for (int i = 0; i < NCOMP; i++)
                    o_comps.val[i] = UNORM_TAB[i_word[8*i +: 8]];
            end
            default: begin
                o_comps.vld = 4'b0001;
                o_comps.val[0] = i_word;
            end
        endcase
    end
endmodule

// ----- hdl/pfds_accum.sv -----
// running counts and extremes; emits totals on the last item
module pfds_accum import pfds_pkg::*; #(parameter int COUNT_BITS = 28) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_comps      i_comps,
    output logic [4*COUNT_BITS+63:0] o_stats,
    output logic        o_done
);
    localparam int CW = COUNT_BITS;
    logic [CW-1:0] r_fin, r_nfin, r_zero, r_nz, n_fin, n_nfin, n_zero, n_nz;
    logic [31:0] r_min, r_max, n_min, n_max;
    logic [2:0] c_fin, c_nfin, c_zero, c_nz;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] c,
                                              input logic [2:0] d);
        logic [CW:0] s;
        s = {1'b0, c} + {{(CW-2){1'b0}}, d};
        sat_add = s[CW] ? {CW{1'b1}} : s[CW-1:0];
    endfunction

    always_comb begin
        logic [31:0] v;
        logic fin;
        c_fin = '0; c_nfin = '0; c_zero = '0; c_nz = '0;
        n_min = r_min; n_max = r_max;
        for (int i = 0; i < NCOMP; i++) begin
            v = i_comps.val[i];
            fin = (v[30:23] != 8'hFF);
            if (i_comps.vld[i]) begin
                if (fin) begin
                    c_fin = c_fin + 3'd1;
                    if (order_key(v) < order_key(n_min)) n_min = v;
                    if (order_key(n_max) < order_key(v)) n_max = v;
                end else c_nfin = c_nfin + 3'd1;
                if (v[30:0] == 31'd0) c_zero = c_zero + 3'd1;
                else c_nz = c_nz + 3'd1;
            end
        end
        n_fin = sat_add(r_fin, c_fin);
        n_nfin = sat_add(r_nfin, c_nfin);
        n_zero = sat_add(r_zero, c_zero);
        n_nz = sat_add(r_nz, c_nz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin <= '0; r_nfin <= '0; r_zero <= '0; r_nz <= '0;
            r_min <= POS_INF; r_max <= NEG_INF;
        end else if (i_en) begin
            if (i_comps.last) begin
                r_fin <= '0; r_nfin <= '0; r_zero <= '0; r_nz <= '0;
                r_min <= POS_INF; r_max <= NEG_INF;
            end else begin
                r_fin <= n_fin; r_nfin <= n_nfin; r_zero <= n_zero; r_nz <= n_nz;
                r_min <= n_min; r_max <= n_max;
            end
        end
    end

    assign o_stats = {n_fin, n_nfin, n_zero, n_nz, n_min, n_max};
    assign o_done = i_en & i_comps.last;
endmodule

// ----- hdl/packed_float_decode_statistics_unit.sv -----
// top level of the packed float decode statistics unit
// Usage: set the pixel format through the cfg channel while idle (2 bits,
// reset 0 = 11/11/10 ufloat, 1 = two halves, 2 = four unorm bytes,
// 3 = float32). Stream words on the in channel: data[31:0] is the raw word,
// data[32] flags the last word of an image. Each accepted word lands in an
// input register; its components are decoded there and folded into the
// running counts and min/max when it advances. On a last word one result
// item carries the four counts (low 28 bits) and the min and max float32
// bits; the statistics then return to their reset values.
// A last word passes the input register and then the result register.
// Throughput: one word per cycle unless a stall holds the input register, set
// by the single decode/accumulate stage. The input register advances whenever
// the result register is free or being drained, so a stalled receiver stalls
// input only while a result waits and another result would need its place.
// Reset clears counts, extremes, the format and all valid flags.
module packed_float_decode_statistics_unit import pfds_pkg::*; #(
    parameter int COUNT_BITS = 28
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pfds_if.sink   cfg,
    pfds_if.sink   in_ch,
    pfds_if.source out_ch
);
    logic [1:0]  r_fmt;
    logic        r_iv;
    logic [31:0] r_word;
    logic        r_last;
    logic        r_ov;
    logic [4*OUT_BITS+63:0] r_out;
    t_comps      comps;
    logic [4*COUNT_BITS+63:0] stats;
    logic        done, adv, out_free;

    assign cfg.ready = 1'b1;
    assign out_free = !r_ov || out_ch.ready;
    // the registered item moves on unless it is a last word blocked by a full result
    assign adv = r_iv && (!r_last || out_free);
    assign in_ch.ready = !r_iv || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= 2'd0;
            r_iv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (cfg.valid) r_fmt <= cfg.data[1:0];
            if (in_ch.ready) r_iv <= in_ch.valid;
            if (done) r_ov <= 1'b1;
            else if (out_ch.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ch.ready && in_ch.valid) begin
            r_word <= in_ch.data[31:0];
            r_last <= in_ch.data[32];
        end
        if (done) begin
            r_out <= {OUT_BITS'(stats[4*COUNT_BITS+63 -: COUNT_BITS]),
                      OUT_BITS'(stats[3*COUNT_BITS+63 -: COUNT_BITS]),
                      OUT_BITS'(stats[2*COUNT_BITS+63 -: COUNT_BITS]),
                      OUT_BITS'(stats[COUNT_BITS+63 -: COUNT_BITS]),
                      stats[63:0]};
        end
    end

    pfds_decode u_dec (.i_fmt(r_fmt), .i_word(r_word), .i_last(r_last), .o_comps(comps));

    pfds_accum #(.COUNT_BITS(COUNT_BITS)) u_acc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(adv), .i_comps(comps),
        .o_stats(stats), .o_done(done)
    );

    assign out_ch.valid = r_ov;
    assign out_ch.data = r_out;
endmodule

// ----- hdl/pfds_checker.sv -----
// port-level checker for the statistics unit, bound to the top level
`include "assert_macros.svh"
module pfds_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic [32:0] in_data,
    input logic out_valid,
    input logic out_ready,
    input logic [175:0] out_data
);
    `CHK_IMPL(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, ##1 out_valid, "result dropped")
    `CHK_IMPL(a_out_stable, i_clk, i_rst_n, out_valid && !out_ready, ##1 $stable(out_data), "result changed")
    `CHK_NEXT(a_nonlast_ready, i_clk, i_rst_n, in_valid && in_ready && !in_data[32], in_ready, "stall after plain word")
    `CHK_IMPL(a_minmax, i_clk, i_rst_n, out_valid && out_data[175:148] == 28'd0, out_data[63:32] == 32'h7F80_0000 && out_data[31:0] == 32'hFF80_0000, "extremes without finite")
endmodule

bind packed_float_decode_statistics_unit pfds_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// ----- dv/packed_float_decode_statistics_unit_tb.sv -----
// testbench for the packed float decode statistics unit: self-checking, random traffic
`timescale 1ns / 1ps

module packed_float_decode_statistics_unit_tb;
    import pfds_pkg::*;

    localparam int      RES_W      = 4 * OUT_BITS + 64;
    localparam int      CNT_BITS   = 28;
    localparam longint  CNT_MAX    = (64'd1 << CNT_BITS) - 1;
    localparam int      IDLE_LIMIT = 20000;

    typedef struct {
        logic [27:0] finite_cnt;
        logic [27:0] nonfinite_cnt;
        logic [27:0] zero_cnt;
        logic [27:0] nonzero_cnt;
        logic [31:0] min_val;
        logic [31:0] max_val;
    } t_stats;

    logic i_clk;
    logic i_rst_n;

    pfds_if #(.W(2))     cfg_if(i_clk);
    pfds_if #(.W(33))    in_if(i_clk);
    pfds_if #(.W(RES_W)) out_if(i_clk);

    packed_float_decode_statistics_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .cfg     (cfg_if.sink),
        .in_ch   (in_if.sink),
        .out_ch  (out_if.source)
    );

    // shadow of the block state
    t_fmt        cur_fmt;
    longint      finite_tot, nonfinite_tot, zero_tot, nonzero_tot;
    logic [31:0] cur_min, cur_max;
    t_stats      stats_q[$];

    int errors;
    int idle_cycles;
    int burst_left;
    int hold_req;
    int hold_cnt;
    int rx_mode;
    int rx_mode_left;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // ---------------- predictor ----------------
    function automatic logic [31:0] scale_denorm(input int unsigned mant, input int mbits);
        int p;
        logic [31:0] e;
        p = 0;
        for (int i = 0; i < 11; i++) if (mant[i]) p = i;
        e = 127 + p - 14 - mbits;
        return (e << 23) | ((mant << (23 - p)) & 32'h7F_FFFF);
    endfunction

    function automatic logic [31:0] small_float(input int unsigned bits, input int mbits);
        int unsigned mant, ex;
        mant = bits & ((1 << mbits) - 1);
        ex   = (bits >> mbits) & 32'h1F;
        if (ex == 0) return (mant != 0) ? scale_denorm(mant, mbits) : 32'd0;
        if (ex == 31) return (mant != 0) ? QNAN : POS_INF;
        return ((ex + 112) << 23) | (mant << (23 - mbits));
    endfunction

    function automatic logic [31:0] half_float(input logic [15:0] h);
        logic [31:0] sgn;
        sgn = {h[15], 31'd0};
        if (h[14:10] == 5'd0)
            return (h[9:0] != 0) ? (sgn | scale_denorm(h[9:0], 10)) : sgn;
        if (h[14:10] == 5'd31) return sgn | POS_INF | (32'(h[9:0]) << 13);
        return sgn | ((32'(h[14:10]) + 112) << 23) | (32'(h[9:0]) << 13);
    endfunction

    // byte/255 rounded to nearest, found by long division
    function automatic logic [31:0] unorm_float(input logic [7:0] b);
        longint unsigned num, q, r;
        int k;
        if (b == 0) return 32'd0;
        k = 23;
        forever begin
            num = longint'(b) << k;
            q = num / 255;
            if (q >= (64'd1 << 23) || k >= 40) break;
            k++;
        end
        r = num - q * 255;
        if (2 * r > 255) q++;
        if (q >= (64'd1 << 24)) begin
            q = q >> 1;
            k--;
        end
        return (32'(150 - k) << 23) | (q[31:0] & 32'h7F_FFFF);
    endfunction

    function automatic logic [31:0] sort_key(input logic [31:0] v);
        logic [31:0] a;
        a = (v[30:0] == 0) ? 32'd0 : v;
        return a[31] ? ~a : (a | 32'h8000_0000);
    endfunction

    function automatic longint bump(input longint c);
        return (c >= CNT_MAX) ? CNT_MAX : c + 1;
    endfunction

    task automatic fold_value(input logic [31:0] v);
        if ((v & POS_INF) != POS_INF) begin
            finite_tot = bump(finite_tot);
            if (sort_key(v) < sort_key(cur_min)) cur_min = v;
            if (sort_key(cur_max) < sort_key(v)) cur_max = v;
        end else begin
            nonfinite_tot = bump(nonfinite_tot);
        end
        if (v[30:0] == 0) zero_tot = bump(zero_tot);
        else nonzero_tot = bump(nonzero_tot);
    endtask

    task automatic clear_stats();
        finite_tot = 0;
        nonfinite_tot = 0;
        zero_tot = 0;
        nonzero_tot = 0;
        cur_min = POS_INF;
        cur_max = NEG_INF;
    endtask

    task automatic predict_word(input logic [31:0] w, input logic last);
        t_stats s;
        case (cur_fmt)
            FMT_UF111110: begin
                fold_value(small_float(w[10:0], 6));
                fold_value(small_float(w[21:11], 6));
                fold_value(small_float(w[31:22], 5));
            end
            FMT_HALF2: begin
                fold_value(half_float(w[15:0]));
                fold_value(half_float(w[31:16]));
            end
            FMT_UNORM4: for (int i = 0; i < 4; i++) fold_value(unorm_float(w[8*i +: 8]));
            default: fold_value(w);
        endcase
        if (last) begin
            s.finite_cnt    = finite_tot[27:0];
            s.nonfinite_cnt = nonfinite_tot[27:0];
            s.zero_cnt      = zero_tot[27:0];
            s.nonzero_cnt   = nonzero_tot[27:0];
            s.min_val       = cur_min;
            s.max_val       = cur_max;
            stats_q.push_back(s);
            clear_stats();
        end
    endtask

    // ---------------- drivers ----------------
    task automatic send_word(input logic [31:0] w, input logic last);
        in_if.valid <= 1'b1;
        in_if.data  <= {last, w};
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_word(w, last);
        burst_left--;
        if (burst_left <= 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
        end
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (stats_q.size() != 0) @(posedge i_clk);
        // a word without last may still be in the pipeline
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_format(input t_fmt f);
        wait_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= f;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cur_fmt = f;
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // force exponent fields of some components, or unorm bytes, to their extremes
    function automatic logic [31:0] shaped_word(input t_fmt f);
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 2) != 0) begin
            case (f)
                FMT_UF111110: begin
                    if ($urandom_range(0, 1)) w[10:6]  = $urandom_range(0, 1) ? 5'd0 : 5'd31;
                    if ($urandom_range(0, 1)) w[21:17] = $urandom_range(0, 1) ? 5'd0 : 5'd31;
                    if ($urandom_range(0, 1)) w[31:27] = $urandom_range(0, 1) ? 5'd0 : 5'd31;
                end
                FMT_HALF2: begin
                    if ($urandom_range(0, 1)) w[14:10] = $urandom_range(0, 1) ? 5'd0 : 5'd31;
                    if ($urandom_range(0, 1)) w[30:26] = $urandom_range(0, 1) ? 5'd0 : 5'd31;
                    if ($urandom_range(0, 3) == 0) w[9:0] = 0;
                end
                FMT_UNORM4: if ($urandom_range(0, 1)) w[8*$urandom_range(0, 3) +: 8] =
                    $urandom_range(0, 1) ? 8'h00 : 8'hFF;
                default: begin
                    w[30:23] = $urandom_range(0, 1) ? 8'd0 : 8'hFF;
                    if ($urandom_range(0, 2) == 0) w[22:0] = 0;
                end
            endcase
        end
        return w;
    endfunction

    // ---------------- receiver and checker ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                t_stats s;
                logic [RES_W-1:0] d;
                d = out_if.data;
                if (stats_q.size() == 0) begin
                    report("result item with nothing expected");
                end else begin
                    s = stats_q.pop_front();
                    if (d[175:148] !== s.finite_cnt)
                        report($sformatf("finite %0d exp %0d", d[175:148], s.finite_cnt));
                    if (d[147:120] !== s.nonfinite_cnt)
                        report($sformatf("nonfinite %0d exp %0d", d[147:120], s.nonfinite_cnt));
                    if (d[119:92] !== s.zero_cnt)
                        report($sformatf("zero %0d exp %0d", d[119:92], s.zero_cnt));
                    if (d[91:64] !== s.nonzero_cnt)
                        report($sformatf("nonzero %0d exp %0d", d[91:64], s.nonzero_cnt));
                    if (d[63:32] !== s.min_val)
                        report($sformatf("min %h exp %h", d[63:32], s.min_val));
                    if (d[31:0] !== s.max_val)
                        report($sformatf("max %h exp %h", d[31:0], s.max_val));
                end
            end
            if (hold_req > 0) begin
                hold_cnt = hold_req;
                hold_req = 0;
            end
            if (rx_mode_left <= 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(50, 300);
            end
            rx_mode_left--;
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_if.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= $urandom_range(0, 1);
                    default: out_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // watchdog on stalled progress
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_small_float();
        write_format(FMT_UF111110);
        send_word(32'h0000_0000, 1'b0);
        send_word({5'd30, 5'h1F, 5'd30, 6'h3F, 5'd30, 6'h3F}, 1'b0);
        send_word({5'd31, 5'd0, 5'd31, 6'd1, 5'd0, 6'd1}, 1'b0);
        send_word({5'd0, 5'd1, 5'd0, 6'h3F, 5'd31, 6'd0}, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_half();
        write_format(FMT_HALF2);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_8000, 1'b0);
        send_word(32'h7C00_FC00, 1'b0);
        send_word(32'h7E01_7C01, 1'b0);
        send_word(32'h83FF_0001, 1'b0);
        send_word(32'hFBFF_7BFF, 1'b1);
        send_word(32'h7C01_FFFF, 1'b1);
    endtask

    task automatic test_unorm();
        write_format(FMT_UNORM4);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFF80_7F01, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_float32();
        write_format(FMT_F32);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'hFF7F_FFFF, 1'b0);
        send_word(32'h7F7F_FFFF, 1'b0);
        send_word(32'h7F80_0000, 1'b1);
        // images with no finite component
        send_word(32'hFFC0_0001, 1'b1);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'hFF80_0000, 1'b1);
    endtask

    task automatic test_random(input t_fmt f, input int n_words);
        int sent;
        int left;
        write_format(f);
        sent = 0;
        while (sent < n_words) begin
            left = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 6);
            for (int i = 0; i < left; i++) begin
                send_word(shaped_word(f), i == left - 1);
                sent++;
            end
        end
    endtask

    // receiver holds off while single-word images keep coming
    task automatic test_backpressure();
        write_format(t_fmt'($urandom_range(0, 3)));
        hold_req = 400;
        burst_left = 1000;
        for (int i = 0; i < 40; i++) send_word($urandom, 1'b1);
        burst_left = 1;
        wait_drained();
    endtask

    initial begin
        errors = 0;
        idle_cycles = 0;
        burst_left = 5;
        hold_req = 0;
        hold_cnt = 0;
        rx_mode = 0;
        rx_mode_left = 0;
        cur_fmt = FMT_UF111110;
        clear_stats();
        i_rst_n <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_small_float();
        test_half();
        test_unorm();
        test_float32();
        test_random(FMT_UF111110, 150);
        test_random(FMT_HALF2, 150);
        test_backpressure();
        test_random(FMT_UNORM4, 150);
        test_random(FMT_F32, 150);
        test_random(t_fmt'($urandom_range(0, 3)), 150);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
